// ----- src/ies_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ies_pkg;

	localparam int IDX_W = 14;
	localparam int POS_W = 32;
	localparam int RAD_W = 31;

	// Default sizes
	localparam int MAX_VERTICES_DEF   = 16384;
	localparam int MAX_OPEN_EDGES_DEF = 8192;
	localparam int POS_FRAC_BITS_DEF  = 16;

	// Request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_BEGIN = 2'd1;
	localparam logic [1:0] REQ_SPLIT = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_FACE   = 2'd1;
	localparam logic [1:0] KIND_ACK    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Result record to build in the output register
	typedef enum logic [3:0] {
		EM_NONE,
		EM_ACK,
		EM_ERR,
		EM_LOAD,
		EM_NEW,
		EM_F0,
		EM_F1,
		EM_F2,
		EM_F3
	} emit_t;

	// Controller to datapath commands
	typedef struct packed {
		logic  capture;
		logic  clr_edges;
		logic  scan_start;
		logic  scan_rd;
		logic  scan_next;
		logic  last_rd;
		logic  hit_wr;
		logic  vrd_s;
		logic  vrd_e;
		logic  avg;
		logic  commit_new;
		logic  commit_load;
		logic  next_edge;
		emit_t emit;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] req;
		logic       load_oob;
		logic       scan_end;
		logic       hit;
		logic       full;
		logic       sel_last;
		logic       out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ----- src/ies_norm.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Iterative normaliser: r = v * radius / floor(|v|), rounded half away from zero
module ies_norm (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [ies_pkg::POS_W-1:0] vx,
	input  wire logic [ies_pkg::POS_W-1:0] vy,
	input  wire logic [ies_pkg::POS_W-1:0] vz,
	input  wire logic [ies_pkg::RAD_W-1:0] radius,
	output logic             done,
	output logic [ies_pkg::POS_W-1:0] rx,
	output logic [ies_pkg::POS_W-1:0] ry,
	output logic [ies_pkg::POS_W-1:0] rz
);
	import ies_pkg::*;

	typedef enum logic [2:0] {
		N_IDLE, N_MUL, N_ACC, N_SQRT, N_DMUL, N_DADD, N_DIV, N_STORE
	} nphase_t;

	nphase_t     phase_q;
	logic [1:0]  cnt_q;
	logic [4:0]  it_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] root_q;
	logic [34:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] quo_q;

	logic [31:0] cv;
	logic [31:0] cmag;
	logic [63:0] sq;
	logic [63:0] sc;
	logic [34:0] srem;
	logic [34:0] strial;
	logic [31:0] root_nxt;
	logic        sqrt_take;
	logic [32:0] drem;
	logic        div_take;
	logic [63:0] dsum;
	logic [31:0] sres;
	logic        zero_end;
	logic        store_end;

	// Component select and magnitude
	always_comb begin
		case (cnt_q)
			2'd0:    cv = vx;
			2'd1:    cv = vy;
			default: cv = vz;
		endcase
		cmag = cv[31] ? (32'd0 - cv) : cv;
	end

	assign sq = cmag * cmag;
	assign sc = cmag * {1'b0, radius};

	// One result bit of the square root per cycle
	assign srem      = {rem_q[32:0], acc_q[63:62]};
	assign strial    = {1'b0, root_q, 2'b01};
	assign sqrt_take = (srem >= strial);
	assign root_nxt  = {root_q[30:0], sqrt_take};

	// One quotient bit per cycle
	assign drem     = {rem_q[31:0], lo_q[31]};
	assign div_take = (drem >= {1'b0, root_q});
	assign dsum     = prod_q + {33'd0, root_q[31:1]};
	assign sres     = cv[31] ? (32'd0 - quo_q) : quo_q;

	// Finish points: zero length after the root, or last component stored
	assign zero_end  = (phase_q == N_SQRT) && (it_q == 5'd31) && (root_nxt == 32'd0);
	assign store_end = (phase_q == N_STORE) && (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= N_IDLE;
			cnt_q   <= 2'd0;
			it_q    <= 5'd0;
			done    <= 1'b0;
		end else begin
			done <= zero_end || store_end;
			case (phase_q)
				N_IDLE: begin
					if (start) begin
						cnt_q   <= 2'd0;
						acc_q   <= 64'd0;
						phase_q <= N_MUL;
					end
				end
				N_MUL: begin
					prod_q  <= sq;
					phase_q <= N_ACC;
				end
				N_ACC: begin
					acc_q <= acc_q + prod_q;
					if (cnt_q == 2'd2) begin
						cnt_q   <= 2'd0;
						it_q    <= 5'd0;
						rem_q   <= 35'd0;
						root_q  <= 32'd0;
						phase_q <= N_SQRT;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						phase_q <= N_MUL;
					end
				end
				N_SQRT: begin
					rem_q  <= sqrt_take ? (srem - strial) : srem;
					root_q <= root_nxt;
					acc_q  <= {acc_q[61:0], 2'b00};
					it_q   <= it_q + 5'd1;
					if (it_q == 5'd31) begin
						if (root_nxt == 32'd0) begin
							// zero-length vector
							rx      <= '0;
							ry      <= '0;
							rz      <= '0;
							phase_q <= N_IDLE;
						end else begin
							phase_q <= N_DMUL;
						end
					end
				end
				N_DMUL: begin
					prod_q  <= sc;
					phase_q <= N_DADD;
				end
				N_DADD: begin
					rem_q   <= {3'd0, dsum[63:32]};
					lo_q    <= dsum[31:0];
					it_q    <= 5'd0;
					phase_q <= N_DIV;
				end
				N_DIV: begin
					rem_q <= div_take ? {2'd0, drem - {1'b0, root_q}} : {2'd0, drem};
					quo_q <= {quo_q[30:0], div_take};
					lo_q  <= {lo_q[30:0], 1'b0};
					it_q  <= it_q + 5'd1;
					if (it_q == 5'd31) begin
						phase_q <= N_STORE;
					end
				end
				N_STORE: begin
					case (cnt_q)
						2'd0:    rx <= sres;
						2'd1:    ry <= sres;
						default: rz <= sres;
					endcase
					if (cnt_q == 2'd2) begin
						phase_q <= N_IDLE;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						phase_q <= N_DMUL;
					end
				end
				default: phase_q <= N_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/ies_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath: vertex and open-edge stores, counters, face corners, output register
module ies_dp #(
	parameter int MAX_VERTICES   = ies_pkg::MAX_VERTICES_DEF,
	parameter int MAX_OPEN_EDGES = ies_pkg::MAX_OPEN_EDGES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ies_pkg::ctl_cmd_t           cmd,
	output ies_pkg::ctl_sts_t                sts,
	input  wire logic [1:0]                  req_type,
	input  wire logic [ies_pkg::IDX_W-1:0]   vert_a,
	input  wire logic [ies_pkg::IDX_W-1:0]   vert_b,
	input  wire logic [ies_pkg::IDX_W-1:0]   vert_c,
	input  wire logic [ies_pkg::POS_W-1:0]   pos_x,
	input  wire logic [ies_pkg::POS_W-1:0]   pos_y,
	input  wire logic [ies_pkg::POS_W-1:0]   pos_z,
	output logic [ies_pkg::POS_W-1:0]        nvx,
	output logic [ies_pkg::POS_W-1:0]        nvy,
	output logic [ies_pkg::POS_W-1:0]        nvz,
	input  wire logic [ies_pkg::POS_W-1:0]   rx,
	input  wire logic [ies_pkg::POS_W-1:0]   ry,
	input  wire logic [ies_pkg::POS_W-1:0]   rz,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       kind,
	output logic [ies_pkg::IDX_W-1:0]        out_a,
	output logic [ies_pkg::IDX_W-1:0]        out_b,
	output logic [ies_pkg::IDX_W-1:0]        out_c,
	output logic [ies_pkg::POS_W-1:0]        out_x,
	output logic [ies_pkg::POS_W-1:0]        out_y,
	output logic [ies_pkg::POS_W-1:0]        out_z,
	output logic                             last
);
	import ies_pkg::*;

	localparam int VA  = $clog2(MAX_VERTICES);
	localparam int EA  = $clog2(MAX_OPEN_EDGES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int ECW = $clog2(MAX_OPEN_EDGES + 1);

	// Stores
	logic [POS_W-1:0] vmem_x [MAX_VERTICES];
	logic [POS_W-1:0] vmem_y [MAX_VERTICES];
	logic [POS_W-1:0] vmem_z [MAX_VERTICES];
	logic [IDX_W-1:0] emem_lo  [MAX_OPEN_EDGES];
	logic [IDX_W-1:0] emem_hi  [MAX_OPEN_EDGES];
	logic [IDX_W-1:0] emem_mid [MAX_OPEN_EDGES];

	logic [1:0]       req_q;
	logic [IDX_W-1:0] a_q, b_q, c_q;
	logic [VCW-1:0]   vcount_q;
	logic [ECW-1:0]   ecount_q;
	logic [ECW-1:0]   scan_q;
	logic [1:0]       sel_q;
	logic [IDX_W-1:0] ab_q, bc_q, ca_q;
	logic [IDX_W-1:0] hmid_q;

	logic [POS_W-1:0] vrx_q, vry_q, vrz_q;
	logic             voob_q;
	logic [POS_W-1:0] px_q, py_q, pz_q;
	logic [IDX_W-1:0] erlo_q, erhi_q, ermid_q;

	logic [IDX_W-1:0] s_idx, e_idx, mid_new, vidx;
	logic [VCW-1:0]   ld_cnt;
	logic             load_oob;
	logic             vwr;
	logic [VA-1:0]    vwaddr;
	logic             ewr;
	logic [EA-1:0]    ewaddr, eraddr;
	logic [IDX_W-1:0] ew_lo, ew_hi, ew_mid;
	logic             out_free;

	logic [1:0]       kind_d;
	logic [IDX_W-1:0] oa_d, ob_d, oc_d;
	logic [POS_W-1:0] ox_d, oy_d, oz_d;
	logic             last_d;

	// Edge endpoints for the current edge: (b,a), (c,b), (a,c)
	always_comb begin
		case (sel_q)
			2'd0:    begin s_idx = b_q; e_idx = a_q; end
			2'd1:    begin s_idx = c_q; e_idx = b_q; end
			default: begin s_idx = a_q; e_idx = c_q; end
		endcase
	end

	assign mid_new  = IDX_W'(vcount_q);
	assign ld_cnt   = VCW'(a_q) + VCW'(1);
	assign load_oob = ({18'd0, a_q} >= 32'(MAX_VERTICES));
	assign out_free = !out_valid || out_ready;

	// Status to the controller
	always_comb begin
		sts.req      = req_q;
		sts.load_oob = load_oob;
		sts.scan_end = (scan_q >= ecount_q);
		sts.hit      = ((erlo_q == s_idx) && (erhi_q == e_idx)) ||
		               ((erlo_q == e_idx) && (erhi_q == s_idx));
		sts.full     = (vcount_q >= VCW'(MAX_VERTICES)) || (ecount_q >= ECW'(MAX_OPEN_EDGES));
		sts.sel_last = (sel_q == 2'd2);
		sts.out_free = out_free;
	end

	// Vertex store
	assign vwr    = cmd.commit_new || cmd.commit_load;
	assign vwaddr = cmd.commit_new ? VA'(vcount_q) : VA'(a_q);
	assign vidx   = cmd.vrd_s ? s_idx : e_idx;

	always_ff @(posedge clk) begin
		if (vwr) begin
			vmem_x[vwaddr] <= rx;
			vmem_y[vwaddr] <= ry;
			vmem_z[vwaddr] <= rz;
		end
		if (cmd.vrd_s || cmd.vrd_e) begin
			vrx_q  <= vmem_x[VA'(vidx)];
			vry_q  <= vmem_y[VA'(vidx)];
			vrz_q  <= vmem_z[VA'(vidx)];
			voob_q <= ({18'd0, vidx} >= 32'(MAX_VERTICES));
		end
	end

	// Open-edge store
	assign ewr    = cmd.hit_wr || cmd.commit_new;
	assign ewaddr = cmd.hit_wr ? EA'(scan_q) : EA'(ecount_q);
	assign ew_lo  = cmd.hit_wr ? erlo_q  : s_idx;
	assign ew_hi  = cmd.hit_wr ? erhi_q  : e_idx;
	assign ew_mid = cmd.hit_wr ? ermid_q : mid_new;
	assign eraddr = cmd.last_rd ? EA'(ecount_q - ECW'(1)) : EA'(scan_q);

	always_ff @(posedge clk) begin
		if (ewr) begin
			emem_lo[ewaddr]  <= ew_lo;
			emem_hi[ewaddr]  <= ew_hi;
			emem_mid[ewaddr] <= ew_mid;
		end
		if (cmd.scan_rd || cmd.last_rd) begin
			erlo_q  <= emem_lo[eraddr];
			erhi_q  <= emem_hi[eraddr];
			ermid_q <= emem_mid[eraddr];
		end
	end

	// Input capture, endpoint average and face corners
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			a_q   <= vert_a;
			b_q   <= vert_b;
			c_q   <= vert_c;
			nvx   <= pos_x;
			nvy   <= pos_y;
			nvz   <= pos_z;
		end
		if (cmd.vrd_e) begin
			px_q <= voob_q ? '0 : vrx_q;
			py_q <= voob_q ? '0 : vry_q;
			pz_q <= voob_q ? '0 : vrz_q;
		end
		if (cmd.avg) begin
			nvx <= avg2(px_q, voob_q ? '0 : vrx_q);
			nvy <= avg2(py_q, voob_q ? '0 : vry_q);
			nvz <= avg2(pz_q, voob_q ? '0 : vrz_q);
		end
		if (cmd.last_rd) begin
			hmid_q <= ermid_q;
		end
		if (cmd.hit_wr || cmd.commit_new) begin
			case (sel_q)
				2'd0:    ab_q <= cmd.hit_wr ? hmid_q : mid_new;
				2'd1:    bc_q <= cmd.hit_wr ? hmid_q : mid_new;
				default: ca_q <= cmd.hit_wr ? hmid_q : mid_new;
			endcase
		end
	end

	// (p+q)/2 truncated toward zero
	function automatic logic [POS_W-1:0] avg2(input logic [POS_W-1:0] p,
	                                          input logic [POS_W-1:0] q);
		logic [POS_W:0] sum;
		logic [POS_W:0] half;
		sum  = {p[POS_W-1], p} + {q[POS_W-1], q};
		half = {sum[POS_W], sum[POS_W:1]};
		if (sum[POS_W] && sum[0]) begin
			half = half + (POS_W+1)'(1);
		end
		return half[POS_W-1:0];
	endfunction

	// Counters and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			ecount_q <= '0;
			scan_q   <= '0;
			sel_q    <= 2'd0;
		end else begin
			if (cmd.capture) begin
				sel_q <= 2'd0;
			end else if (cmd.next_edge) begin
				sel_q <= sel_q + 2'd1;
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + ECW'(1);
			end
			if (cmd.clr_edges) begin
				ecount_q <= '0;
			end else if (cmd.hit_wr) begin
				ecount_q <= ecount_q - ECW'(1);
			end else if (cmd.commit_new) begin
				ecount_q <= ecount_q + ECW'(1);
			end
			if (cmd.commit_new) begin
				vcount_q <= vcount_q + VCW'(1);
			end else if (cmd.commit_load && (vcount_q < ld_cnt)) begin
				vcount_q <= ld_cnt;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit != EM_NONE) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Next record fields
	always_comb begin
		kind_d = KIND_FACE;
		oa_d   = '0;
		ob_d   = '0;
		oc_d   = '0;
		ox_d   = '0;
		oy_d   = '0;
		oz_d   = '0;
		last_d = 1'b0;
		case (cmd.emit)
			EM_ACK: begin
				kind_d = KIND_ACK;
				last_d = 1'b1;
			end
			EM_ERR: begin
				kind_d = KIND_ERROR;
				last_d = 1'b1;
			end
			EM_LOAD: begin
				kind_d = KIND_VERTEX;
				oa_d   = a_q;
				ox_d   = rx;
				oy_d   = ry;
				oz_d   = rz;
				last_d = 1'b1;
			end
			EM_NEW: begin
				kind_d = KIND_VERTEX;
				oa_d   = mid_new;
				ox_d   = rx;
				oy_d   = ry;
				oz_d   = rz;
			end
			EM_F0: begin
				oa_d = a_q;
				ob_d = ab_q;
				oc_d = ca_q;
			end
			EM_F1: begin
				oa_d = ca_q;
				ob_d = ab_q;
				oc_d = bc_q;
			end
			EM_F2: begin
				oa_d = ca_q;
				ob_d = bc_q;
				oc_d = c_q;
			end
			EM_F3: begin
				oa_d   = ab_q;
				ob_d   = b_q;
				oc_d   = bc_q;
				last_d = 1'b1;
			end
			default: kind_d = KIND_ACK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EM_NONE) begin
			kind  <= kind_d;
			out_a <= oa_d;
			out_b <= ob_d;
			out_c <= oc_d;
			out_x <= ox_d;
			out_y <= oy_d;
			out_z <= oz_d;
			last  <= last_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/ies_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for load, begin-pass and split-face transactions
module ies_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ies_pkg::ctl_sts_t sts,
	input  wire logic              norm_done,
	output logic                   norm_start,
	output ies_pkg::ctl_cmd_t      cmd
);
	import ies_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_LNORM, S_LCOMMIT, S_ACK, S_ERR,
		S_SCAN, S_CMP, S_HRD, S_HWR, S_NEXT,
		S_VRD_S, S_VRD_E, S_AVG, S_NWAIT, S_NCOMMIT,
		S_F0, S_F1, S_F2, S_F3
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	// Commands decoded from the current state
	always_comb begin
		cmd            = '0;
		cmd.emit       = EM_NONE;
		norm_start     = 1'b0;
		cmd.capture    = in_valid && (state_q == S_IDLE);
		case (state_q)
			S_DECODE: begin
				case (sts.req)
					REQ_LOAD:  norm_start = !sts.load_oob;
					REQ_BEGIN: cmd.clr_edges = 1'b1;
					REQ_SPLIT: cmd.scan_start = 1'b1;
					default:   cmd.clr_edges = 1'b0;
				endcase
			end
			S_LCOMMIT: begin
				cmd.commit_load = sts.out_free;
				cmd.emit        = sts.out_free ? EM_LOAD : EM_NONE;
			end
			S_ACK:   cmd.emit = sts.out_free ? EM_ACK : EM_NONE;
			S_ERR:   cmd.emit = sts.out_free ? EM_ERR : EM_NONE;
			S_SCAN:  cmd.scan_rd = !sts.scan_end;
			S_CMP:   cmd.scan_next = !sts.hit;
			S_HRD:   cmd.last_rd = 1'b1;
			S_HWR:   cmd.hit_wr = 1'b1;
			S_NEXT: begin
				cmd.next_edge  = !sts.sel_last;
				cmd.scan_start = !sts.sel_last;
			end
			S_VRD_S: cmd.vrd_s = 1'b1;
			S_VRD_E: cmd.vrd_e = 1'b1;
			S_AVG: begin
				cmd.avg    = 1'b1;
				norm_start = 1'b1;
			end
			S_NCOMMIT: begin
				cmd.commit_new = sts.out_free;
				cmd.emit       = sts.out_free ? EM_NEW : EM_NONE;
			end
			S_F0:    cmd.emit = sts.out_free ? EM_F0 : EM_NONE;
			S_F1:    cmd.emit = sts.out_free ? EM_F1 : EM_NONE;
			S_F2:    cmd.emit = sts.out_free ? EM_F2 : EM_NONE;
			S_F3:    cmd.emit = sts.out_free ? EM_F3 : EM_NONE;
			default: cmd.emit = EM_NONE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					case (sts.req)
						REQ_LOAD:  state_q <= sts.load_oob ? S_ERR : S_LNORM;
						REQ_SPLIT: state_q <= S_SCAN;
						default:   state_q <= S_ACK;
					endcase
				end
				S_LNORM: begin
					if (norm_done) state_q <= S_LCOMMIT;
				end
				S_LCOMMIT, S_ACK, S_ERR, S_F3: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (!sts.scan_end) state_q <= S_CMP;
					else if (sts.full) state_q <= S_ERR;
					else               state_q <= S_VRD_S;
				end
				S_CMP:   state_q <= sts.hit ? S_HRD : S_SCAN;
				S_HRD:   state_q <= S_HWR;
				S_HWR:   state_q <= S_NEXT;
				S_NEXT:  state_q <= sts.sel_last ? S_F0 : S_SCAN;
				S_VRD_S: state_q <= S_VRD_E;
				S_VRD_E: state_q <= S_AVG;
				S_AVG:   state_q <= S_NWAIT;
				S_NWAIT: begin
					if (norm_done) state_q <= S_NCOMMIT;
				end
				S_NCOMMIT: begin
					if (sts.out_free) state_q <= S_NEXT;
				end
				S_F0: begin
					if (sts.out_free) state_q <= S_F1;
				end
				S_F1: begin
					if (sts.out_free) state_q <= S_F2;
				end
				S_F2: begin
					if (sts.out_free) state_q <= S_F3;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/icosphere_edge_midpoint_subdivider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sphere mesh midpoint subdivider.
// Input channel (in_valid/in_ready) takes one request per transaction: load a
// vertex, begin a subdivision pass, or split a face. Output channel
// (out_valid/out_ready) returns vertex, face, acknowledge or error records;
// last marks the final record of each request.
// One request is worked on at a time. A load runs the normaliser: squaring of
// each component, a bit-serial square root, then a bit-serial divide per
// component. A split scans the open edges for each edge of its triangle and
// runs the normaliser once for each new midpoint.
// A finished record waits in the output register; while out_ready is low the
// sequencer holds before writing the next record, and a new request may be
// accepted while the final record of the previous one is still waiting.
// Reset empties the vertex and open-edge counts and sets radius to 1.0; the
// stores themselves are not cleared. Radius is written over the APB port at
// paddr[2] low. The user must write it only while idle; the block does not check.
module icosphere_edge_midpoint_subdivider #(
	parameter int MAX_VERTICES   = ies_pkg::MAX_VERTICES_DEF,
	parameter int MAX_OPEN_EDGES = ies_pkg::MAX_OPEN_EDGES_DEF,
	parameter int POS_FRAC_BITS  = ies_pkg::POS_FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                req_type,
	input  wire logic [ies_pkg::IDX_W-1:0] vert_a,
	input  wire logic [ies_pkg::IDX_W-1:0] vert_b,
	input  wire logic [ies_pkg::IDX_W-1:0] vert_c,
	input  wire logic [ies_pkg::POS_W-1:0] pos_x,
	input  wire logic [ies_pkg::POS_W-1:0] pos_y,
	input  wire logic [ies_pkg::POS_W-1:0] pos_z,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     kind,
	output logic [ies_pkg::IDX_W-1:0]      out_a,
	output logic [ies_pkg::IDX_W-1:0]      out_b,
	output logic [ies_pkg::IDX_W-1:0]      out_c,
	output logic [ies_pkg::POS_W-1:0]      out_x,
	output logic [ies_pkg::POS_W-1:0]      out_y,
	output logic [ies_pkg::POS_W-1:0]      out_z,
	output logic                           last
);
	import ies_pkg::*;

	logic [RAD_W-1:0] radius_q;
	ctl_cmd_t         cmd;
	ctl_sts_t         sts;
	logic             norm_start;
	logic             norm_done;
	logic [POS_W-1:0] nvx, nvy, nvz;
	logic [POS_W-1:0] rx, ry, rz;

	// Radius register
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {1'b0, radius_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(1) << POS_FRAC_BITS;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			radius_q <= pwdata[RAD_W-1:0];
		end
	end

	ies_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sts        (sts),
		.norm_done  (norm_done),
		.norm_start (norm_start),
		.cmd        (cmd)
	);

	ies_dp #(
		.MAX_VERTICES   (MAX_VERTICES),
		.MAX_OPEN_EDGES (MAX_OPEN_EDGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req_type),
		.vert_a    (vert_a),
		.vert_b    (vert_b),
		.vert_c    (vert_c),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.nvx       (nvx),
		.nvy       (nvy),
		.nvz       (nvz),
		.rx        (rx),
		.ry        (ry),
		.rz        (rz),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.out_a     (out_a),
		.out_b     (out_b),
		.out_c     (out_c),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.last      (last)
	);

	ies_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vx     (nvx),
		.vy     (nvy),
		.vz     (nvz),
		.radius (radius_q),
		.done   (norm_done),
		.rx     (rx),
		.ry     (ry),
		.rz     (rz)
	);

endmodule
`default_nettype wire

// ----- dv/icosphere_edge_midpoint_subdivider_tb.sv -----
`timescale 1ns / 1ps
module icosphere_edge_midpoint_subdivider_tb;
	import ies_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int MAXV = MAX_VERTICES_DEF;
	localparam int MAXE = MAX_OPEN_EDGES_DEF;
	localparam int STALL_LIMIT = 40000;
	localparam int N_RANDOM = 350;

	typedef struct packed {
		logic [1:0]  kind;
		logic [13:0] a;
		logic [13:0] b;
		logic [13:0] c;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
	} rec_t;

	typedef struct packed {
		logic [1:0]  req;
		logic [13:0] a;
		logic [13:0] b;
		logic [13:0] c;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        typed;
		logic [1:0]  ek;
		logic [31:0] ex;
		logic [31:0] ey;
		logic [31:0] ez;
	} row_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} vec_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] req_type;
	logic [13:0] vert_a, vert_b, vert_c;
	logic [31:0] pos_x, pos_y, pos_z;
	logic out_valid, out_ready;
	logic [1:0] kind;
	logic [13:0] out_a, out_b, out_c;
	logic [31:0] out_x, out_y, out_z;
	logic last;

	icosphere_edge_midpoint_subdivider uut (.*);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// mirror of the block's state
	logic [63:0] radius_m;
	logic [31:0] vtx_x[int];
	logic [31:0] vtx_y[int];
	logic [31:0] vtx_z[int];
	int vtx_cnt;
	int edge_lo[MAXE];
	int edge_hi[MAXE];
	int edge_mid[MAXE];
	int edge_cnt;
	int mesh_pool[$];

	rec_t pending_recs[$];
	int mismatches;
	bit no_idle;

	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > n) bt = bt >> 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] scale_comp(input longint v, input logic [63:0] n);
		logic [63:0] m, q;
		m = (v < 0) ? 64'(-v) : 64'(v);
		q = (m * radius_m + n / 2) / n;
		return (v < 0) ? 32'(-q) : 32'(q);
	endfunction

	// normalise and scale by the radius; zero length gives zero
	function automatic vec_t on_sphere(input longint vx, input longint vy, input longint vz);
		logic [63:0] ax, ay, az, n;
		vec_t r;
		ax = (vx < 0) ? 64'(-vx) : 64'(vx);
		ay = (vy < 0) ? 64'(-vy) : 64'(vy);
		az = (vz < 0) ? 64'(-vz) : 64'(vz);
		n = isqrt(ax * ax + ay * ay + az * az);
		r = '0;
		if (n != 0) begin
			r.x = scale_comp(vx, n);
			r.y = scale_comp(vy, n);
			r.z = scale_comp(vz, n);
		end
		return r;
	endfunction

	function automatic rec_t mk_rec(input logic [1:0] k, input int a, input int b, input int c,
			input vec_t p, input logic l);
		rec_t r;
		r.kind = k;
		r.a = 14'(a);
		r.b = 14'(b);
		r.c = 14'(c);
		r.x = p.x;
		r.y = p.y;
		r.z = p.z;
		r.last = l;
		return r;
	endfunction

	function automatic void store_vertex(input int i, input vec_t p);
		vtx_x[i] = p.x;
		vtx_y[i] = p.y;
		vtx_z[i] = p.z;
		mesh_pool.push_back(i);
	endfunction

	// open-edge lookup; -1 when no open edge matches and either store is full
	function automatic int edge_midpoint(input int s, input int e);
		int i, res;
		vec_t p;
		for (i = 0; i < edge_cnt; i++) begin
			if ((edge_lo[i] == s && edge_hi[i] == e) || (edge_lo[i] == e && edge_hi[i] == s)) begin
				res = edge_mid[i];
				edge_cnt--;
				edge_lo[i] = edge_lo[edge_cnt];
				edge_hi[i] = edge_hi[edge_cnt];
				edge_mid[i] = edge_mid[edge_cnt];
				return res;
			end
		end
		if (vtx_cnt >= MAXV || edge_cnt >= MAXE) return -1;
		p = on_sphere((longint'($signed(vtx_x[s])) + longint'($signed(vtx_x[e]))) / 2,
			(longint'($signed(vtx_y[s])) + longint'($signed(vtx_y[e]))) / 2,
			(longint'($signed(vtx_z[s])) + longint'($signed(vtx_z[e]))) / 2);
		store_vertex(vtx_cnt, p);
		edge_lo[edge_cnt] = s;
		edge_hi[edge_cnt] = e;
		edge_mid[edge_cnt] = vtx_cnt;
		edge_cnt++;
		pending_recs.push_back(mk_rec(KIND_VERTEX, vtx_cnt, 0, 0, p, 1'b0));
		vtx_cnt++;
		return vtx_cnt - 1;
	endfunction

	// expected records for one accepted transaction
	function automatic void predict(input row_t t);
		int a, b, c, ab, bc, ca;
		vec_t p;
		a = t.a;
		b = t.b;
		c = t.c;
		case (t.req)
			REQ_LOAD: begin
				p = on_sphere(longint'($signed(t.x)), longint'($signed(t.y)), longint'($signed(t.z)));
				store_vertex(a, p);
				if (vtx_cnt < a + 1) vtx_cnt = a + 1;
				pending_recs.push_back(mk_rec(KIND_VERTEX, a, 0, 0, p, 1'b1));
			end
			REQ_SPLIT: begin
				ab = edge_midpoint(b, a);
				bc = (ab < 0) ? -1 : edge_midpoint(c, b);
				ca = (bc < 0) ? -1 : edge_midpoint(a, c);
				if (ca < 0) begin
					pending_recs.push_back(mk_rec(KIND_ERROR, 0, 0, 0, '0, 1'b1));
				end else begin
					pending_recs.push_back(mk_rec(KIND_FACE, a, ab, ca, '0, 1'b0));
					pending_recs.push_back(mk_rec(KIND_FACE, ca, ab, bc, '0, 1'b0));
					pending_recs.push_back(mk_rec(KIND_FACE, ca, bc, c, '0, 1'b0));
					pending_recs.push_back(mk_rec(KIND_FACE, ab, b, bc, '0, 1'b1));
				end
			end
			default: begin
				if (t.req == REQ_BEGIN) edge_cnt = 0;
				pending_recs.push_back(mk_rec(KIND_ACK, 0, 0, 0, '0, 1'b1));
			end
		endcase
		// hand-typed expectation replaces the predicted one
		if (t.typed) begin
			p.x = t.ex;
			p.y = t.ey;
			p.z = t.ez;
			pending_recs[pending_recs.size() - 1] = mk_rec(t.ek, a, 0, 0, p, 1'b1);
			if (t.ek == KIND_ACK) pending_recs[pending_recs.size() - 1].a = '0;
		end
	endfunction

	// output checker
	always @(posedge clk) begin
		rec_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, out_a, out_b, out_c, out_x, out_y, out_z, last};
			if (pending_recs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: kind %0d a %0d b %0d c %0d", kind, out_a,
						out_b, out_c);
			end else begin
				want = pending_recs.pop_front();
				if (got.kind !== want.kind || got.a !== want.a || got.b !== want.b ||
						got.c !== want.c || got.x !== want.x || got.y !== want.y ||
						got.z !== want.z || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp k%0d a%0d b%0d c%0d %h %h %h l%0d / got k%0d a%0d b%0d c%0d %h %h %h l%0d",
							want.kind, want.a, want.b, want.c, want.x, want.y, want.z,
							want.last, got.kind, got.a, got.b, got.c, got.x, got.y, got.z,
							got.last);
				end
			end
		end
	end

	// watchdog on transactions
	int stall_cyc;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cyc <= 0;
		else stall_cyc <= stall_cyc + 1;
		if (stall_cyc >= STALL_LIMIT) begin
			$display("icosphere_edge_midpoint_subdivider: mismatch");
			$finish;
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 21);
	end

	task automatic send(input row_t t);
		bit done;
		done = 0;
		while (!done) begin
			@(negedge clk);
			if (!no_idle && $urandom_range(0, 99) < 21) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				req_type <= t.req;
				vert_a <= t.a;
				vert_b <= t.b;
				vert_c <= t.c;
				pos_x <= t.x;
				pos_y <= t.y;
				pos_z <= t.z;
				do @(posedge clk); while (!in_ready);
				predict(t);
				done = 1;
			end
		end
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_radius(input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= v;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		radius_m = {33'd0, v[30:0]};
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
			2: return 32'($urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000);
			default: return 32'($urandom_range(0, 3) - 1);
		endcase
	endfunction

	function automatic int pick_corner();
		int n;
		n = mesh_pool.size();
		if ($urandom_range(0, 9) == 0) return mesh_pool[$urandom_range(0, n - 1)];
		return mesh_pool[n - 1 - $urandom_range(0, (n < 12 ? n : 12) - 1)];
	endfunction

	row_t dir_tab[] = '{
		'{REQ_BEGIN, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_ACK, 32'd0, 32'd0, 32'd0},
		'{REQ_LOAD, 14'd0, 14'd0, 14'd0, 32'h0001_0000, 32'd0, 32'd0,
			1'b1, KIND_VERTEX, 32'h0001_0000, 32'd0, 32'd0},
		'{REQ_LOAD, 14'd1, 14'h3FFF, 14'h3FFF, 32'd0, 32'h8000_0000, 32'd0,
			1'b1, KIND_VERTEX, 32'd0, 32'hFFFF_0000, 32'd0},
		'{REQ_LOAD, 14'd2, 14'd0, 14'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
			1'b1, KIND_VERTEX, 32'd0, 32'd0, 32'h0001_0000},
		'{REQ_LOAD, 14'd3, 14'd0, 14'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_VERTEX, 32'd0, 32'd0, 32'd0},
		'{REQ_LOAD, 14'd4, 14'd0, 14'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, KIND_VERTEX, 32'd0, 32'd0, 32'd0},
		'{REQ_LOAD, 14'd5, 14'd0, 14'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			1'b0, KIND_VERTEX, 32'd0, 32'd0, 32'd0},
		'{REQ_LOAD, 14'd6, 14'd0, 14'd0, 32'hFFFF_0000, 32'd0, 32'd0,
			1'b1, KIND_VERTEX, 32'hFFFF_0000, 32'd0, 32'd0},
		'{REQ_UNUSED, 14'h3FFF, 14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, KIND_ACK, 32'd0, 32'd0, 32'd0},
		'{REQ_SPLIT, 14'd0, 14'd1, 14'd2, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FACE, 32'd0, 32'd0, 32'd0},
		'{REQ_SPLIT, 14'd2, 14'd1, 14'd0, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FACE, 32'd0, 32'd0, 32'd0},
		'{REQ_SPLIT, 14'd0, 14'd6, 14'd3, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FACE, 32'd0, 32'd0, 32'd0},
		'{REQ_SPLIT, 14'd4, 14'd4, 14'd4, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FACE, 32'd0, 32'd0, 32'd0},
		'{REQ_SPLIT, 14'd5, 14'd4, 14'd0, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FACE, 32'd0, 32'd0, 32'd0},
		'{REQ_BEGIN, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_ACK, 32'd0, 32'd0, 32'd0},
		'{REQ_SPLIT, 14'd0, 14'd1, 14'd2, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FACE, 32'd0, 32'd0, 32'd0}
	};

	initial begin
		row_t t;
		int i, sel;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = '0;
		vert_a = '0;
		vert_b = '0;
		vert_c = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		out_ready = 1'b0;
		no_idle = 1'b0;
		mismatches = 0;
		vtx_cnt = 0;
		edge_cnt = 0;
		radius_m = 64'h1_0000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_radius(32'h0001_0000);

		// directed transactions
		foreach (dir_tab[i]) send(dir_tab[i]);
		drain();

		// random transactions, radius changed between phases
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 90 || i == 180 || i == 270) begin
				drain();
				case (i)
					90: write_radius(32'd0);
					180: write_radius(32'hFFFF_FFFF);
					default: write_radius($urandom);
				endcase
			end
			no_idle = (i >= 200 && i < 260);
			t = '0;
			t.b = 14'($urandom);
			t.c = 14'($urandom);
			t.x = rand_coord();
			t.y = rand_coord();
			t.z = rand_coord();
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				t.req = REQ_LOAD;
				t.a = 14'($urandom_range(0, 4) == 0 ? pick_corner() : vtx_cnt + $urandom_range(0, 2));
			end else if (sel < 20) begin
				t.req = REQ_BEGIN;
				t.a = 14'($urandom);
			end else if (sel < 22) begin
				t.req = REQ_UNUSED;
				t.a = 14'($urandom);
			end else begin
				t.req = REQ_SPLIT;
				t.a = 14'(pick_corner());
				t.b = 14'(pick_corner());
				t.c = 14'(pick_corner());
			end
			send(t);
		end
		drain();

		// top index fills the vertex store: every later miss overflows
		write_radius(32'h0001_0000);
		t = '0;
		t.req = REQ_LOAD;
		t.a = 14'h3FFF;
		t.x = 32'h0000_1000;
		t.y = 32'hFFFF_F000;
		t.z = 32'h0000_0800;
		send(t);
		t.req = REQ_SPLIT;
		t.a = 14'd0;
		t.b = 14'h3FFF;
		t.c = 14'h3FFF;
		send(t);
		t.a = 14'h3FFF;
		t.b = 14'd1;
		t.c = 14'h3FFF;
		send(t);
		t.a = 14'd0;
		t.b = 14'd1;
		t.c = 14'd2;
		send(t);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0) begin
			$display("icosphere_edge_midpoint_subdivider: match");
		end else begin
			$display("icosphere_edge_midpoint_subdivider: mismatch");
		end
		$finish;
	end

endmodule

// ----- icosphere_edge_midpoint_subdivider.f -----
src/ies_pkg.sv
src/ies_norm.sv
src/ies_dp.sv
src/ies_ctrl.sv
src/icosphere_edge_midpoint_subdivider.sv
dv/icosphere_edge_midpoint_subdivider_tb.sv
